// File: sv/dpf_pkg.sv
`timescale 1ns / 1ps

package dpf_pkg;

    // Sizes of the framer
    localparam int BUFFER_DEPTH  = 32;
    localparam int PATTERN_BYTES = 8;

    localparam int PAT_W     = PATTERN_BYTES * 8;
    localparam int PAT_IDX_W = 3;
    localparam int LEN_W     = 4;
    localparam int POS_W     = $clog2(BUFFER_DEPTH);
    localparam int LIMIT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_PATTERN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT  = 3'd4;

    // Event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STORED   = 3'd1;
    localparam logic [2:0] EV_START    = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } dpf_in_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [7:0]         stored_byte;
        logic [POS_W-1:0]   write_position;
        logic [LIMIT_W-1:0] packet_length;
    } dpf_out_t;

    // Effective configuration, lengths and limit already clamped
    typedef struct packed {
        logic [PAT_W-1:0]   start_pattern;
        logic [LEN_W-1:0]   start_len;
        logic [PAT_W-1:0]   end_pattern;
        logic [LEN_W-1:0]   end_len;
        logic [LIMIT_W-1:0] limit;
    } dpf_cfg_t;

    // State clears caused by register writes
    typedef struct packed {
        logic clr_start;
        logic clr_end;
        logic clr_all;
    } dpf_clr_t;

endpackage

// File: sv/delimited_packet_framer.sv
`timescale 1ns / 1ps
// A result item appears on m_ in the cycle after its input item is accepted.
// Throughput: one item per cycle; the framing state is updated in the same cycle.
// s_ready drops only while a finished result waits in the output register.
// Reset (aresetn, synchronous, active low) clears the framing state, empties the
// output register and loads the registers with their defaults (buffer limit 32).

module delimited_packet_framer
    import dpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dpf_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpf_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    dpf_cfg_t cfg;
    dpf_clr_t clr;

    // Framing state
    logic [POS_W-1:0] wr_idx_reg, wr_idx_next;
    logic [LEN_W-1:0] s_cnt_reg, s_cnt_next;
    logic [LEN_W-1:0] e_cnt_reg, e_cnt_next;
    logic             in_pkt_reg, in_pkt_next;

    // Output register
    logic     m_valid_reg;
    dpf_out_t m_data_reg;
    dpf_out_t res;

    logic [LEN_W-1:0]   s_cnt_m, e_cnt_m;
    logic               s_hit, e_hit;
    logic [POS_W-1:0]   wi;
    logic [LIMIT_W-1:0] wi_inc;
    logic               done;
    logic               accept;

    dpf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clr       (clr)
    );

    // Start and end delimiters are tracked by two independent matchers.
    dpf_match u_start (
        .pattern   (cfg.start_pattern),
        .len       (cfg.start_len),
        .cnt       (s_cnt_reg),
        .data_byte (s_data.data_byte),
        .cnt_next  (s_cnt_m),
        .hit       (s_hit)
    );

    dpf_match u_end (
        .pattern   (cfg.end_pattern),
        .len       (cfg.end_len),
        .cnt       (e_cnt_reg),
        .data_byte (s_data.data_byte),
        .cnt_next  (e_cnt_m),
        .hit       (e_hit)
    );

    // A new item is taken whenever the output register is empty or is being
    // emptied in this cycle, so items can follow each other without a gap.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // One pass over the item: delimiter matching, then storing the byte.
    always_comb begin
        // A write position left at or beyond a lowered limit wraps first.
        wi = ({1'b0, wr_idx_reg} >= cfg.limit) ? '0 : wr_idx_reg;
        wi_inc = {1'b0, wi} + LIMIT_W'(1);

        wr_idx_next = wi;
        s_cnt_next  = s_cnt_reg;
        e_cnt_next  = e_cnt_reg;
        in_pkt_next = in_pkt_reg;
        done        = 1'b0;

        res.event_res      = EV_NONE;
        res.stored_byte    = '0;
        res.write_position = '0;
        res.packet_length  = '0;

        if (s_data.action == ACT_CLEAR) begin
            wr_idx_next = '0;
            s_cnt_next  = '0;
            e_cnt_next  = '0;
            in_pkt_next = 1'b0;
        end else begin
            if (cfg.start_len != '0) begin
                s_cnt_next = s_cnt_m;
                if (s_hit) begin
                    // Completed start delimiter: (re)open the packet.
                    wr_idx_next   = '0;
                    e_cnt_next    = '0;
                    s_cnt_next    = '0;
                    in_pkt_next   = 1'b1;
                    res.event_res = EV_START;
                    done          = 1'b1;
                end else if (!in_pkt_reg) begin
                    // Outside a packet the byte is dropped.
                    done = 1'b1;
                end
            end
            if (!done) begin
                res.stored_byte    = s_data.data_byte;
                res.write_position = wi;
                res.event_res      = EV_STORED;
                if (cfg.end_len != '0 && e_hit) begin
                    // Completed end delimiter: the length excludes the
                    // delimiter, and a packet shorter than it reports zero.
                    res.event_res = EV_COMPLETE;
                    if ({1'b0, wi} >= LIMIT_W'(cfg.end_len)) begin
                        res.packet_length = wi_inc - LIMIT_W'(cfg.end_len);
                    end
                    wr_idx_next = '0;
                    e_cnt_next  = '0;
                    s_cnt_next  = '0;
                    in_pkt_next = 1'b0;
                end else begin
                    if (cfg.end_len != '0) begin
                        e_cnt_next = e_cnt_m;
                    end
                    if (wi_inc >= cfg.limit) begin
                        // The buffer is full: the position wraps round.
                        wr_idx_next       = '0;
                        res.event_res     = EV_OVERFLOW;
                        res.packet_length = cfg.limit;
                    end else begin
                        wr_idx_next = wi_inc[POS_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            s_cnt_reg  <= '0;
            e_cnt_reg  <= '0;
            in_pkt_reg <= 1'b0;
        end else if (clr.clr_all) begin
            wr_idx_reg <= '0;
            s_cnt_reg  <= '0;
            e_cnt_reg  <= '0;
            in_pkt_reg <= 1'b0;
        end else if (clr.clr_start || clr.clr_end) begin
            // Writing a delimiter register restarts only its own matcher;
            // a new start delimiter also closes any open packet.
            if (clr.clr_start) begin
                s_cnt_reg  <= '0;
                in_pkt_reg <= 1'b0;
            end
            if (clr.clr_end) begin
                e_cnt_reg <= '0;
            end
        end else if (accept) begin
            wr_idx_reg <= wr_idx_next;
            s_cnt_reg  <= s_cnt_next;
            e_cnt_reg  <= e_cnt_next;
            in_pkt_reg <= in_pkt_next;
        end
    end

    // Every accepted item gives exactly one result item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/dpf_cfg.sv
`timescale 1ns / 1ps

module dpf_cfg
    import dpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output dpf_cfg_t             cfg,
    output dpf_clr_t             clr
);

    dpf_cfg_t           cfg_reg;
    logic [LEN_W-1:0]   len_clamped;
    logic [LIMIT_W-1:0] lim_raw;
    logic [LIMIT_W-1:0] lim_clamped;
    logic               wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    // Lengths above the pattern size behave as the full pattern size.
    always_comb begin
        if (cfg_data[LEN_W-1:0] > LEN_W'(PATTERN_BYTES)) begin
            len_clamped = LEN_W'(PATTERN_BYTES);
        end else begin
            len_clamped = cfg_data[LEN_W-1:0];
        end
        lim_raw = cfg_data[LIMIT_W-1:0];
        if (lim_raw == '0) begin
            lim_clamped = LIMIT_W'(1);
        end else if (lim_raw > LIMIT_W'(BUFFER_DEPTH)) begin
            lim_clamped = LIMIT_W'(BUFFER_DEPTH);
        end else begin
            lim_clamped = lim_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_pattern <= '0;
            cfg_reg.start_len     <= '0;
            cfg_reg.end_pattern   <= '0;
            cfg_reg.end_len       <= '0;
            cfg_reg.limit         <= LIMIT_W'(BUFFER_DEPTH);
        end else if (wr) begin
            case (cfg_index)
                REG_START_PATTERN: cfg_reg.start_pattern <= cfg_data[PAT_W-1:0];
                REG_START_LENGTH:  cfg_reg.start_len     <= len_clamped;
                REG_END_PATTERN:   cfg_reg.end_pattern   <= cfg_data[PAT_W-1:0];
                REG_END_LENGTH:    cfg_reg.end_len       <= len_clamped;
                REG_BUFFER_LIMIT:  cfg_reg.limit         <= lim_clamped;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        clr.clr_start = wr && (cfg_index == REG_START_PATTERN ||
                               cfg_index == REG_START_LENGTH);
        clr.clr_end   = wr && (cfg_index == REG_END_PATTERN ||
                               cfg_index == REG_END_LENGTH);
        clr.clr_all   = wr && (cfg_index == REG_BUFFER_LIMIT);
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/dpf_match.sv
`timescale 1ns / 1ps

module dpf_match
    import dpf_pkg::*;
(
    input  logic [PAT_W-1:0] pattern,
    input  logic [LEN_W-1:0] len,
    input  logic [LEN_W-1:0] cnt,
    input  logic [7:0]       data_byte,
    output logic [LEN_W-1:0] cnt_next,
    output logic             hit
);

    logic [LEN_W-1:0] c;

    // Naive match: a stale count restarts, a mismatch retries the first byte.
    always_comb begin
        c = (cnt >= len) ? '0 : cnt;
        if (data_byte != pattern[c[PAT_IDX_W-1:0]*8 +: 8]) begin
            c = '0;
        end
        hit      = 1'b0;
        cnt_next = c;
        if (data_byte == pattern[c[PAT_IDX_W-1:0]*8 +: 8]) begin
            cnt_next = c + LEN_W'(1);
            hit      = (cnt_next >= len);
        end
    end

endmodule

// File: dv/tb_delimited_packet_framer.sv
`timescale 1ns / 1ps

module tb_delimited_packet_framer;
    import dpf_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;
    // Generous ceiling on the run: the slowest correct run stays far below it.
    localparam int CYCLE_LIMIT = 250000;
    localparam int STALL_PERCENT = 7;
    localparam int REPORT_LIMIT = 10;
    // The register map leaves indexes above the buffer limit unused.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    dpf_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    dpf_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    delimited_packet_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Framer events still owed by the block, oldest first.
    dpf_out_t due_events[$];

    int  error_count;
    bit  stall_en;       // random idling on both channels

    // Shadow copy of the register file, exactly as written.
    logic [PAT_W-1:0] start_pat;
    logic [LEN_W-1:0] start_len_reg;
    logic [PAT_W-1:0] end_pat;
    logic [LEN_W-1:0] end_len_reg;
    logic [5:0]       limit_reg;

    // Shadow framing state.
    int wr_idx;
    int start_cnt;
    int end_cnt;
    bit in_pkt;

    // The clock simply toggles every half period from time zero.
    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow framer
    // ------------------------------------------------------------------

    // A delimiter length above the pattern width behaves as the full width.
    function automatic int eff_len(logic [LEN_W-1:0] len);
        return (len > PATTERN_BYTES) ? PATTERN_BYTES : int'(len);
    endfunction

    // The limit register saturates at both ends: 0 acts as 1, anything past the
    // buffer depth acts as the depth.
    function automatic int eff_limit();
        if (limit_reg == 0)
            return 1;
        if (limit_reg > BUFFER_DEPTH)
            return BUFFER_DEPTH;
        return int'(limit_reg);
    endfunction

    function automatic void clear_framing();
        wr_idx = 0;
        start_cnt = 0;
        end_cnt = 0;
        in_pkt = 1'b0;
    endfunction

    // Naive delimiter matcher. On a mismatch the count falls to zero and the
    // very same byte is tried again against the first delimiter byte. The
    // whole delimiter has been seen when the new count reaches the length.
    function automatic int next_match_count(logic [PAT_W-1:0] pat, int len, int cnt,
                                            logic [7:0] b);
        int c;
        c = (cnt >= len) ? 0 : cnt;
        if (b != pat[(c % 8) * 8 +: 8])
            c = 0;
        if (b == pat[(c % 8) * 8 +: 8])
            c++;
        return c;
    endfunction

    // Works out the event that one accepted item causes and moves the shadow
    // state on by that item.
    function automatic dpf_out_t frame_byte(dpf_in_t item);
        dpf_out_t res;
        int       slen;
        int       elen;
        int       lim;
        int       nxt;
        bit       keep;
        res  = '0;
        slen = eff_len(start_len_reg);
        elen = eff_len(end_len_reg);
        lim  = eff_limit();
        if (wr_idx >= lim)
            wr_idx = 0;
        res.event_res = EV_NONE;
        if (item.action == ACT_CLEAR) begin
            clear_framing();
        end else begin
            keep = 1'b1;
            if (slen > 0) begin
                nxt = next_match_count(start_pat, slen, start_cnt, item.data_byte);
                if (nxt >= slen) begin
                    // A full start delimiter opens a fresh packet; its last
                    // byte is never stored.
                    wr_idx = 0;
                    end_cnt = 0;
                    start_cnt = 0;
                    in_pkt = 1'b1;
                    res.event_res = EV_START;
                    keep = 1'b0;
                end else begin
                    start_cnt = nxt;
                    // Outside a packet the byte is dropped.
                    if (!in_pkt)
                        keep = 1'b0;
                end
            end
            if (keep) begin
                res.stored_byte = item.data_byte;
                res.write_position = wr_idx[POS_W-1:0];
                res.event_res = EV_STORED;
                nxt = (elen > 0) ? next_match_count(end_pat, elen, end_cnt, item.data_byte) : 0;
                if (elen > 0 && nxt >= elen) begin
                    // The length excludes the end delimiter; a packet shorter
                    // than the delimiter reports zero.
                    res.event_res = EV_COMPLETE;
                    res.packet_length = (wr_idx >= elen) ? LIMIT_W'(wr_idx + 1 - elen) : '0;
                    wr_idx = 0;
                    end_cnt = 0;
                    start_cnt = 0;
                    in_pkt = 1'b0;
                end else begin
                    if (elen > 0)
                        end_cnt = nxt;
                    wr_idx++;
                    if (wr_idx >= lim) begin
                        wr_idx = 0;
                        res.event_res = EV_OVERFLOW;
                        res.packet_length = LIMIT_W'(lim);
                    end
                end
            end
        end
        return res;
    endfunction

    // Register writes also clear the parts of the framing state that depend on
    // the register written.
    function automatic void store_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_START_PATTERN: begin
                start_pat = val;
                start_cnt = 0;
                in_pkt = 1'b0;
            end
            REG_START_LENGTH: begin
                start_len_reg = val[LEN_W-1:0];
                start_cnt = 0;
                in_pkt = 1'b0;
            end
            REG_END_PATTERN: begin
                end_pat = val;
                end_cnt = 0;
            end
            REG_END_LENGTH: begin
                end_len_reg = val[LEN_W-1:0];
                end_cnt = 0;
            end
            REG_BUFFER_LIMIT: begin
                limit_reg = val[5:0];
                clear_framing();
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls at random on the falling edge, so that a stall can
    // land on any phase of the block's work.
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= !(stall_en && $urandom_range(0, 99) < STALL_PERCENT);
    end

    task automatic note_mismatch(input string what, input dpf_out_t want, input dpf_out_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %0s: expected ev=%0d byte=%02h pos=%0d len=%0d, got ev=%0d byte=%02h pos=%0d len=%0d",
                     $realtime, what, want.event_res, want.stored_byte, want.write_position,
                     want.packet_length, got.event_res, got.stored_byte, got.write_position,
                     got.packet_length);
    endtask

    // Each result item is compared field by field with the oldest outstanding
    // event. Sampling happens on the rising edge, before the block updates.
    always @(posedge aclk) begin
        dpf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_events.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0, m_data);
            end else begin
                want = due_events.pop_front();
                if (m_data.event_res !== want.event_res ||
                    m_data.stored_byte !== want.stored_byte ||
                    m_data.write_position !== want.write_position ||
                    m_data.packet_length !== want.packet_length)
                    note_mismatch("result mismatch", want, m_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Offers one item and returns at the falling edge after it was taken.
    // Valid is left high, so the next item may follow without a bubble; only
    // an idle cycle or a pause lowers it.
    task automatic offer_item(input logic act, input logic [7:0] b);
        dpf_in_t  item;
        dpf_out_t ev;
        while (stall_en && $urandom_range(0, 99) < STALL_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        item.action = act;
        item.data_byte = b;
        s_valid <= 1'b1;
        s_data <= item;
        do
            @(posedge aclk);
        while (!s_ready);
        ev = frame_byte(item);
        due_events.push_back(ev);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every outstanding event has come back,
    // then idles before returning, since the block registers its answer to an
    // item that it has taken.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (due_events.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        store_register(idx, val);
        @(negedge aclk);
    endtask

    // Loads the whole register file while the block is idle. Length and limit
    // writes may carry junk in the unused upper bits when asked.
    task automatic configure_framer(input logic [PAT_W-1:0] sp, input logic [LEN_W-1:0] sl,
                                    input logic [PAT_W-1:0] ep, input logic [LEN_W-1:0] el,
                                    input logic [5:0] lim, input bit junk);
        logic [CFG_DAT_W-1:0] upper;
        pause_until_drained();
        upper = junk ? {$urandom, $urandom} : '0;
        write_register(REG_START_PATTERN, sp);
        write_register(REG_START_LENGTH, {upper[CFG_DAT_W-1:LEN_W], sl});
        write_register(REG_END_PATTERN, ep);
        write_register(REG_END_LENGTH, {upper[CFG_DAT_W-1:LEN_W], el});
        write_register(REG_BUFFER_LIMIT, {upper[CFG_DAT_W-1:6], lim});
        if (junk && $urandom_range(0, 3) == 0)
            write_register(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Sends the first bytes of a delimiter, in order.
    task automatic send_delimiter(input logic [PAT_W-1:0] pat, input int count);
        for (int i = 0; i < count; i++)
            offer_item(ACT_APPEND, pat[i * 8 +: 8]);
    endtask

    // Payload bytes lean towards delimiter bytes so that partial matches and
    // restarts of the matchers happen often.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            return start_pat[$urandom_range(0, 7) * 8 +: 8];
        if (sel < 40)
            return end_pat[$urandom_range(0, 7) * 8 +: 8];
        return 8'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return LEN_W'($urandom_range(PATTERN_BYTES + 1, 15));
        if (sel < 5)
            return LEN_W'(PATTERN_BYTES);
        return LEN_W'($urandom_range(1, PATTERN_BYTES));
    endfunction

    // Mostly ordinary limits, sometimes the saturating values at either end.
    function automatic logic [5:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return 6'($urandom_range(BUFFER_DEPTH + 1, 63));
        if (sel < 4)
            return 6'($urandom_range(1, 3));
        return 6'($urandom_range(1, BUFFER_DEPTH));
    endfunction

    function automatic logic [PAT_W-1:0] pick_pattern();
        logic [7:0] b;
        // A run of one repeated byte stresses the naive matcher.
        if ($urandom_range(0, 4) == 0) begin
            b = 8'($urandom);
            return {PATTERN_BYTES{b}};
        end
        return {$urandom, $urandom};
    endfunction

    // Streams random traffic until about the given number of items has been
    // sent. Most of it is whole packets: start delimiter, payload, end
    // delimiter. The rest is broken starts, loose noise, clears and the odd
    // pause.
    task automatic run_framing_phase(input int target);
        int sent;
        int sel;
        int plen;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                plen = ($urandom_range(0, 6) == 0) ? $urandom_range(0, eff_limit() + 4)
                                                   : $urandom_range(0, 6);
                send_delimiter(start_pat, eff_len(start_len_reg));
                for (int i = 0; i < plen; i++)
                    offer_item(ACT_APPEND, pick_byte());
                send_delimiter(end_pat, eff_len(end_len_reg));
                sent += plen + eff_len(start_len_reg) + eff_len(end_len_reg);
            end else if (sel < 80) begin
                plen = $urandom_range(0, eff_len(start_len_reg));
                send_delimiter(start_pat, plen);
                sent += plen;
            end else if (sel < 95) begin
                plen = $urandom_range(1, 4);
                for (int i = 0; i < plen; i++)
                    offer_item(ACT_APPEND, 8'($urandom));
                sent += plen;
            end else if (sel < 98) begin
                offer_item(ACT_CLEAR, 8'($urandom));
                sent++;
            end else begin
                pause_until_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, no delimiters: all bytes stored; a clear rewinds to 0.
    task automatic test_plain_stream();
        offer_item(ACT_APPEND, 8'h00);
        offer_item(ACT_APPEND, 8'hFF);
        offer_item(ACT_CLEAR, 8'hFF);
        offer_item(ACT_APPEND, 8'h80);
    endtask

    // Noise before the start is dropped, an ordinary packet completes, and an
    // empty packet, with only the end delimiter stored, reports length zero.
    task automatic test_delimited_packet();
        configure_framer(64'h5AA5, 4'd2, 64'h3CC3, 4'd2, 6'd32, 1'b0);
        offer_item(ACT_APPEND, 8'h11);
        send_delimiter(start_pat, 2);
        offer_item(ACT_APPEND, 8'h00);
        offer_item(ACT_APPEND, 8'hFF);
        send_delimiter(end_pat, 2);
        send_delimiter(start_pat, 2);
        send_delimiter(end_pat, 2);
    endtask

    // A second start delimiter inside a packet restarts it; its first byte
    // has already been stored by then.
    task automatic test_restart_in_packet();
        send_delimiter(start_pat, 2);
        offer_item(ACT_APPEND, 8'h77);
        send_delimiter(start_pat, 2);
        offer_item(ACT_APPEND, 8'h3C);
        send_delimiter(end_pat, 2);
    endtask

    // Saturating registers: an oversized end length, a zero limit that wraps
    // on every byte, and a limit above the buffer depth.
    task automatic test_limits_and_clamps();
        configure_framer('0, 4'd0, {$urandom, $urandom}, 4'd15, 6'd0, 1'b0);
        offer_item(ACT_APPEND, 8'h42);
        offer_item(ACT_APPEND, 8'h43);
        configure_framer('0, 4'd0, '1, 4'd15, 6'd63, 1'b1);
        offer_item(ACT_APPEND, 8'hFF);
        offer_item(ACT_CLEAR, 8'h00);
    endtask

    // Random framing over many register settings. The first two phases use
    // the extremes: widest delimiters with the deepest buffer, then the
    // narrowest with the smallest buffer. Each reconfiguration first lets
    // the block run dry.
    task automatic test_random_framing();
        for (int p = 0; p < 10; p++) begin
            if (p == 0)
                configure_framer('1, LEN_W'(PATTERN_BYTES), '0, LEN_W'(PATTERN_BYTES),
                                 6'(BUFFER_DEPTH), 1'b0);
            else if (p == 1)
                configure_framer(pick_pattern(), 4'd1, pick_pattern(), 4'd1, 6'd1, 1'b1);
            else
                configure_framer(pick_pattern(), pick_length(), pick_pattern(), pick_length(),
                                 pick_limit(), $urandom_range(0, 1));
            run_framing_phase(130);
        end
    endtask

    // A long stretch with no random stalls on either side, so that items
    // flow back to back at full rate between the odd pauses.
    task automatic test_back_to_back_stream();
        configure_framer(pick_pattern(), LEN_W'($urandom_range(1, PATTERN_BYTES)), pick_pattern(),
                         LEN_W'($urandom_range(1, PATTERN_BYTES)), 6'($urandom_range(4, 32)),
                         1'b0);
        stall_en = 1'b0;
        run_framing_phase(250);
        stall_en = 1'b1;
    endtask

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        stall_en = 1'b1;
        start_pat = '0;
        start_len_reg = '0;
        end_pat = '0;
        end_len_reg = '0;
        limit_reg = 6'(BUFFER_DEPTH);
        clear_framing();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_plain_stream();
        test_delimited_packet();
        test_restart_in_packet();
        test_limits_and_clamps();
        test_random_framing();
        test_back_to_back_stream();

        pause_until_drained();
        repeat (5) @(posedge aclk);
        error_count += due_events.size();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
